[src/lzss_pkg.sv]
// Shared constants and codes for the LZSS decompressor.
package lzss_pkg;

  // Parser phases.
  localparam logic [2:0] PH_FLAG  = 3'd0;
  localparam logic [2:0] PH_LIT   = 3'd1;
  localparam logic [2:0] PH_TOKLO = 3'd2;
  localparam logic [2:0] PH_TOKHI = 3'd3;
  localparam logic [2:0] PH_EXTRA = 3'd4;
  localparam logic [2:0] PH_MATCH = 3'd5;

  // Request kinds.
  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes.
  localparam logic REG_LARGE_WINDOW  = 1'b0;
  localparam logic REG_OUTPUT_LENGTH = 1'b1;

  // Format constants.
  localparam int          LEN_W     = 9;
  localparam logic [3:0]  LEN_ESC   = 4'hF;
  localparam logic [8:0]  LEN_BIAS  = 9'd3;
  localparam logic [15:0] FLAG_FILL = 16'hFF00;
  localparam int          FLAG_LIVE = 8;

  // Width of the remainder unit operands (positions up to 4096).
  localparam int MOD_W = 13;

endpackage

[src/lzss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/lzss_mod_unit.sv]
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module lzss_mod_unit import lzss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MOD_W-1:0] dividend,
  input  logic [MOD_W-1:0] divisor,
  output logic             done,
  output logic [MOD_W-1:0] remainder
);

  localparam int CW = $clog2(MOD_W + 1);

  logic          active;
  logic [CW-1:0] cnt;
  logic [MOD_W-1:0] quo;
  logic [MOD_W-1:0] div;
  logic [MOD_W:0]   trial;

  assign trial = {remainder, quo[MOD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active    <= 1'b1;
        cnt       <= '0;
        quo       <= dividend;
        div       <= divisor;
        remainder <= '0;
      end else if (active) begin
        if (trial >= {1'b0, div}) begin
          remainder <= MOD_W'(trial - {1'b0, div});
        end else begin
          remainder <= trial[MOD_W-1:0];
        end
        quo <= {quo[MOD_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MOD_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

[src/lzss_decompressor_two_pass_dict.sv]
// LZSS decompressor top level: parser, dictionary, staging buffer and output register.
// A literal goes from its request straight into the output register; a match byte first
// passes through the MREAD and MDATA states. One request is taken at a time, and only once
// the output register is empty, so a receiver that is not ready holds requests off. A read
// position wrap holds the next request off while the remainder unit runs, and the write-back
// at the end of a match runs WBRD and WBWR for each match byte. Reset and every write of
// output_length run a clearing pass over every dictionary entry, with no request accepted.
module lzss_decompressor_two_pass_dict import lzss_pkg::*; #(
  parameter int DICT_DEPTH    = 4096,
  parameter int STAGING_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] opcode
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tuser,   // [0] match_pending
  output logic        m_tlast,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_data
);

  localparam int AW  = $clog2(DICT_DEPTH);
  localparam int FW  = $clog2(DICT_DEPTH + 1);
  localparam int SAW = $clog2(STAGING_DEPTH);
  localparam logic [FW-1:0] CAP_LARGE = FW'(DICT_DEPTH);
  localparam logic [FW-1:0] CAP_SMALL = FW'(DICT_DEPTH / 2);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MREAD = 3'd3;
  localparam logic [2:0] ST_MDATA = 3'd4;
  localparam logic [2:0] ST_WRAP  = 3'd5;
  localparam logic [2:0] ST_WBRD  = 3'd6;
  localparam logic [2:0] ST_WBWR  = 3'd7;

  logic [2:0]       state;
  logic [2:0]       wrap_dest;
  logic             large_window;
  logic [31:0]      bytes_left;
  logic [AW-1:0]    clr_cnt;
  logic [15:0]      flag_shift;
  logic [2:0]       phase;
  logic [7:0]       token_low;
  logic [7:0]       token_high;
  logic [AW-1:0]    read_position;
  logic [AW-1:0]    write_position;
  logic [FW-1:0]    dict_fill;
  logic [LEN_W-1:0] match_remaining;
  logic [LEN_W-1:0] match_total;
  logic [LEN_W-1:0] wb_k;

  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_pend;
  logic             out_last;

  // Window capacity and the dictionary insert position.
  logic [FW-1:0]    cap;
  logic [AW-1:0]    wp_eff;
  logic [AW-1:0]    wp_inc;
  logic [FW-1:0]    fill_inc;

  assign cap    = large_window ? CAP_LARGE : CAP_SMALL;
  assign wp_eff = ({1'b0, write_position} >= (AW+1)'(cap)) ? '0 : write_position;
  assign wp_inc = (({1'b0, wp_eff} + 1'b1) == (AW+1)'(cap)) ? '0 : wp_eff + 1'b1;
  assign fill_inc = (dict_fill < cap) ? dict_fill + 1'b1 : dict_fill;

  // Advance to the next flag decision.
  logic [15:0] fs_sh;
  logic [2:0]  phase_ni;

  assign fs_sh = flag_shift >> 1;
  always_comb begin
    if (!fs_sh[FLAG_LIVE]) begin
      phase_ni = PH_FLAG;
    end else if (fs_sh[0]) begin
      phase_ni = PH_LIT;
    end else begin
      phase_ni = PH_TOKLO;
    end
  end

  // A request is taken only when the output register is empty, so every
  // result finds room when it is produced.
  logic acc;
  logic live;
  assign s_tready = (state == ST_IDLE) && !out_valid;
  assign acc      = s_tvalid && s_tready;
  assign live     = bytes_left != '0;

  // Match setup from a completed token.
  logic             tok_start;
  logic [7:0]       tok_hi;
  logic [7:0]       tok_extra;
  logic [LEN_W-1:0] tok_len;
  logic [11:0]      tok_pos;

  always_comb begin
    tok_start = 1'b0;
    tok_hi    = token_high;
    tok_extra = 8'd0;
    if (acc && live && s_tuser == OP_FEED) begin
      if (phase == PH_TOKHI && token_low[3:0] != LEN_ESC) begin
        tok_start = 1'b1;
        tok_hi    = s_tdata;
      end else if (phase == PH_EXTRA) begin
        tok_start = 1'b1;
        tok_extra = s_tdata;
      end
    end
  end

  assign tok_len = LEN_W'(token_low[3:0]) + LEN_W'(tok_extra) + LEN_BIAS;
  assign tok_pos = {tok_hi, token_low[7:4]};

  // Match byte arithmetic.
  logic [7:0]       dict_rdata;
  logic [7:0]       stg_rdata;
  logic [LEN_W-1:0] rem_dec;
  logic [31:0]      bl_dec;
  logic [MOD_W-1:0] rp_inc;

  assign rem_dec = match_remaining - 1'b1;
  assign bl_dec  = bytes_left - 1'b1;
  assign rp_inc  = MOD_W'(read_position) + 1'b1;

  // Remainder unit: the read position wraps modulo the current fill. The token
  // position is folded into the power-of-two window by a mask instead.
  logic             mod_start;
  logic [MOD_W-1:0] mod_dividend;
  logic [MOD_W-1:0] mod_divisor;
  logic             mod_done;
  logic [MOD_W-1:0] mod_rem;
  logic             rp_wrap;

  assign rp_wrap = (state == ST_MDATA) && (dict_fill != '0) && (rp_inc >= MOD_W'(dict_fill));

  assign mod_start    = rp_wrap;
  assign mod_dividend = rp_inc;
  assign mod_divisor  = MOD_W'(dict_fill);

  lzss_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Dictionary write port: clearing pass, literals and match write-back.
  logic          lit_put;
  logic          dict_we;
  logic [AW-1:0] dict_waddr;
  logic [7:0]    dict_wdata;

  assign lit_put = acc && live && s_tuser == OP_FEED && phase == PH_LIT;

  always_comb begin
    dict_we    = 1'b0;
    dict_waddr = wp_eff;
    dict_wdata = s_tdata;
    if (state == ST_CLEAR) begin
      dict_we    = 1'b1;
      dict_waddr = clr_cnt;
      dict_wdata = 8'd0;
    end else if (state == ST_WBWR) begin
      dict_we    = 1'b1;
      dict_wdata = stg_rdata;
    end else if (lit_put) begin
      dict_we = 1'b1;
    end
  end

  lzss_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .raddr (read_position),
    .rdata (dict_rdata)
  );

  // Staging buffer collects match bytes until the match is complete.
  logic stg_we;
  assign stg_we = state == ST_MDATA;

  lzss_ram #(.WIDTH(8), .DEPTH(STAGING_DEPTH)) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .waddr (SAW'(match_total - match_remaining)),
    .wdata (dict_rdata),
    .raddr (SAW'(wb_k)),
    .rdata (stg_rdata)
  );

  logic emit;
  assign emit = lit_put || state == ST_MDATA;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      wrap_dest       <= ST_IDLE;
      large_window    <= 1'b1;
      bytes_left      <= '0;
      clr_cnt         <= '0;
      flag_shift      <= '0;
      phase           <= PH_FLAG;
      token_low       <= '0;
      token_high      <= '0;
      read_position   <= '0;
      write_position  <= '0;
      dict_fill       <= '0;
      match_remaining <= '0;
      match_total     <= '0;
      wb_k            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DICT_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (acc && live) begin
            if (s_tuser == OP_DRAIN) begin
              if (phase == PH_MATCH && match_remaining != '0) begin
                state <= ST_MREAD;
              end
            end else begin
              case (phase)
                PH_FLAG: begin
                  flag_shift <= {8'd0, s_tdata} | FLAG_FILL;
                  phase      <= s_tdata[0] ? PH_LIT : PH_TOKLO;
                end
                PH_LIT: begin
                  write_position <= wp_inc;
                  dict_fill      <= fill_inc;
                  bytes_left     <= bl_dec;
                  if (bl_dec != '0) begin
                    flag_shift <= fs_sh;
                    phase      <= phase_ni;
                  end
                end
                PH_TOKLO: begin
                  token_low <= s_tdata;
                  phase     <= PH_TOKHI;
                end
                PH_TOKHI: begin
                  token_high <= s_tdata;
                  if (token_low[3:0] == LEN_ESC) begin
                    phase <= PH_EXTRA;
                  end
                end
                default: ;
              endcase
              if (tok_start) begin
                match_total     <= tok_len;
                match_remaining <= tok_len;
                read_position   <= tok_pos[AW-1:0] & AW'(cap - 1'b1);
                state           <= ST_MREAD;
              end
            end
          end
        end

        ST_MREAD: begin
          state <= ST_MDATA;
        end

        ST_MDATA: begin
          match_remaining <= rem_dec;
          bytes_left      <= bl_dec;
          if (dict_fill == '0) begin
            read_position <= '0;
          end else if (!rp_wrap) begin
            read_position <= rp_inc[AW-1:0];
          end
          if (bl_dec == '0) begin
            match_remaining <= '0;
            phase           <= PH_FLAG;
            wrap_dest       <= ST_IDLE;
            state           <= rp_wrap ? ST_WRAP : ST_IDLE;
          end else if (rem_dec == '0) begin
            wb_k      <= '0;
            wrap_dest <= ST_WBRD;
            state     <= rp_wrap ? ST_WRAP : ST_WBRD;
          end else begin
            phase     <= PH_MATCH;
            wrap_dest <= ST_IDLE;
            state     <= rp_wrap ? ST_WRAP : ST_IDLE;
          end
        end

        ST_WRAP: begin
          if (mod_done) begin
            read_position <= mod_rem[AW-1:0];
            state         <= wrap_dest;
          end
        end

        ST_WBRD: begin
          state <= ST_WBWR;
        end

        ST_WBWR: begin
          write_position <= wp_inc;
          dict_fill      <= fill_inc;
          wb_k           <= wb_k + 1'b1;
          if (wb_k + 1'b1 == match_total) begin
            flag_shift <= fs_sh;
            phase      <= phase_ni;
            state      <= ST_IDLE;
          end else begin
            state <= ST_WBRD;
          end
        end

        default: state <= ST_IDLE;
      endcase

      if (emit) begin
        out_valid <= 1'b1;
        out_byte  <= lit_put ? s_tdata : dict_rdata;
        out_pend  <= !lit_put && bl_dec != '0 && rem_dec != '0;
        out_last  <= bl_dec == '0;
      end

      // Configuration writes take effect at once.
      if (cfg_we) begin
        if (cfg_addr == REG_LARGE_WINDOW) begin
          large_window <= cfg_data[0];
          if ({1'b0, write_position} >= (AW+1)'(cfg_data[0] ? CAP_LARGE : CAP_SMALL)) begin
            write_position <= '0;
          end
          if (dict_fill > (cfg_data[0] ? CAP_LARGE : CAP_SMALL)) begin
            dict_fill <= cfg_data[0] ? CAP_LARGE : CAP_SMALL;
          end
          if (!cfg_data[0] && {1'b0, read_position} >= (AW+1)'(CAP_SMALL)) begin
            read_position <= AW'({1'b0, read_position} - (AW+1)'(CAP_SMALL));
          end
        end else begin
          state           <= ST_CLEAR;
          clr_cnt         <= '0;
          bytes_left      <= cfg_data;
          flag_shift      <= '0;
          phase           <= PH_FLAG;
          token_low       <= '0;
          token_high      <= '0;
          read_position   <= '0;
          write_position  <= '0;
          dict_fill       <= '0;
          match_remaining <= '0;
          match_total     <= '0;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_pend;
  assign m_tlast  = out_last;

  // A new result never lands on one that is still waiting.
  a_emit_room: assert property (@(posedge clk) disable iff (rst) emit |-> !out_valid)
    else $error("result produced while output register full");

  // Waiting for a drain implies bytes remain in the match.
  a_match_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && phase == PH_MATCH) |-> match_remaining != '0)
    else $error("match phase with nothing pending");

  // The fill never exceeds the current window.
  a_fill_cap: assert property (@(posedge clk) disable iff (rst) dict_fill <= cap)
    else $error("dictionary fill beyond window");

  // Remaining match bytes never exceed the match length.
  a_rem_total: assert property (@(posedge clk) disable iff (rst)
    match_remaining <= match_total)
    else $error("match remaining exceeds total");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the LZSS decompressor with a two-pass dictionary.
module testbench;
  import lzss_pkg::*;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // Block inputs start at known values; the outputs are plain wires.
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tuser  = OP_FEED;
  logic        m_tready = 1'b0;
  logic        cfg_we   = 1'b0;
  logic        cfg_addr = REG_LARGE_WINDOW;
  logic [31:0] cfg_data = 32'd0;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  lzss_decompressor_two_pass_dict uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // One request into the block and one decoded byte out of it.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pending;
    logic       last;
  } decoded_t;

  request_t request_q[$];   // requests waiting for the driver
  decoded_t decoded_q[$];   // decoded bytes the block still owes us
  int       mismatches = 0;
  int       hold_request = 0;

  // ---------------------------------------------------------------------------
  // Decoder shadow. It mirrors the block's state and is stepped once for every
  // request the block accepts, pushing the byte the block must produce, if any.
  // ---------------------------------------------------------------------------
  logic [7:0]  dict_mem[4096];
  logic [7:0]  stage_mem[512];
  logic        win_large;
  logic [31:0] out_len;
  logic [15:0] flags;
  logic [2:0]  phase;
  logic [7:0]  tok_lo;
  logic [7:0]  tok_hi;
  logic [11:0] rd_pos;
  logic [8:0]  run_left;
  logic [8:0]  run_total;
  logic [11:0] wr_pos;
  logic [12:0] fill;
  logic [31:0] bytes_left;

  function automatic int window_bytes();
    return win_large ? 4096 : 2048;
  endfunction

  // Writing output_length restarts the stream from an empty dictionary.
  task automatic restart_stream();
    foreach (dict_mem[i]) dict_mem[i] = 8'd0;
    flags = 16'd0;
    phase = PH_FLAG;
    tok_lo = 8'd0;
    tok_hi = 8'd0;
    rd_pos = 12'd0;
    run_left = 9'd0;
    run_total = 9'd0;
    wr_pos = 12'd0;
    fill = 13'd0;
    bytes_left = out_len;
  endtask

  task automatic dict_append(input logic [7:0] b);
    int cap;
    cap = window_bytes();
    if (wr_pos >= cap) wr_pos = 12'd0;
    dict_mem[wr_pos] = b;
    wr_pos = 12'((int'(wr_pos) + 1) % cap);
    if (fill < cap) fill = fill + 13'd1;
  endtask

  // Advance to the next flag decision; bit 8 marks that live decisions remain.
  task automatic next_decision();
    flags = flags >> 1;
    if (!flags[FLAG_LIVE]) phase = PH_FLAG;
    else phase = flags[0] ? PH_LIT : PH_TOKLO;
  endtask

  task automatic push_decoded(input logic [7:0] b, input logic p, input logic l);
    decoded_t d;
    d.data = b;
    d.pending = p;
    d.last = l;
    decoded_q = {decoded_q, d};
  endtask

  // One byte of a match. The copies are staged and only written back into the
  // dictionary once the whole match is out, so a match never sees its own bytes.
  task automatic copy_byte();
    logic [7:0] b;
    b = dict_mem[rd_pos];
    stage_mem[int'(run_total - run_left) % 512] = b;
    run_left = run_left - 9'd1;
    rd_pos = (fill != 0) ? 12'((int'(rd_pos) + 1) % int'(fill)) : 12'd0;
    bytes_left = bytes_left - 32'd1;
    if (bytes_left == 0) begin
      // The stream ends inside or at the end of a match: no write-back.
      run_left = 9'd0;
      phase = PH_FLAG;
      push_decoded(b, 1'b0, 1'b1);
    end else if (run_left == 0) begin
      for (int k = 0; k < run_total; k++) dict_append(stage_mem[k % 512]);
      next_decision();
      push_decoded(b, 1'b0, 1'b0);
    end else begin
      phase = PH_MATCH;
      push_decoded(b, 1'b1, 1'b0);
    end
  endtask

  task automatic open_match(input logic [7:0] extra);
    logic [15:0] tok;
    tok = {tok_hi, tok_lo};
    rd_pos = 12'(int'(tok[15:4]) % window_bytes());
    run_total = 9'(tok[3:0]) + 9'(extra) + LEN_BIAS;
    run_left = run_total;
    copy_byte();
  endtask

  task automatic decode_request(input request_t r);
    if (bytes_left == 0) return;
    if (r.op == OP_DRAIN) begin
      if (phase == PH_MATCH && run_left != 0) copy_byte();
      return;
    end
    case (phase)
      PH_FLAG: begin
        flags = {8'd0, r.data} | FLAG_FILL;
        phase = flags[0] ? PH_LIT : PH_TOKLO;
      end
      PH_LIT: begin
        dict_append(r.data);
        bytes_left = bytes_left - 32'd1;
        push_decoded(r.data, 1'b0, bytes_left == 0);
        if (bytes_left != 0) next_decision();
      end
      PH_TOKLO: begin
        tok_lo = r.data;
        phase = PH_TOKHI;
      end
      PH_TOKHI: begin
        tok_hi = r.data;
        if (tok_lo[3:0] == LEN_ESC) phase = PH_EXTRA;
        else open_match(8'd0);
      end
      PH_EXTRA: open_match(r.data);
      default: ;
    endcase
  endtask

  // Register writes go to the shadow at the same moment they reach the block.
  task automatic write_reg(input logic addr, input logic [31:0] value);
    int cap;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    if (addr == REG_LARGE_WINDOW) begin
      win_large = value[0];
      cap = window_bytes();
      if (wr_pos >= cap) wr_pos = 12'd0;
      if (fill > cap) fill = 13'(cap);
      rd_pos = 12'(int'(rd_pos) % cap);
    end else begin
      out_len = value;
      restart_stream();
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests with random gaps and steps the shadow on
  // every accepted request. Some stretches run without any gap.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    logic     valid_next;
    request_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      valid_next = s_tvalid;
      if (s_tvalid && s_tready) begin
        decode_request('{op: s_tuser, data: s_tdata});
        valid_next = 1'b0;
      end
      if (!valid_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          r = request_q.pop_front();
          s_tdata <= r.data;
          s_tuser <= r.op;
          valid_next = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else begin
            gap_left = pick_gap();
            if ($urandom_range(0, 40) == 0) burst_left = $urandom_range(16, 64);
          end
        end
      end
      s_tvalid <= valid_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure plus one long hold-off on request, and a
  // field-by-field comparison of every accepted byte against the oldest one due.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    logic     ready_next;
    decoded_t d;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected byte %02h pending=%b last=%b", m_tdata, m_tuser, m_tlast);
        end else begin
          d = decoded_q.pop_front();
          if (m_tdata !== d.data || m_tuser !== d.pending || m_tlast !== d.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("byte mismatch: expected %02h pending=%b last=%b, got %02h pending=%b last=%b",
                       d.data, d.pending, d.last, m_tdata, m_tuser, m_tlast);
          end
        end
      end
      if (hold_request != 0) begin
        hold_request = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      m_tready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic op, input logic [7:0] b);
    request_t r;
    r.op = op;
    r.data = b;
    request_q = {request_q, r};
  endtask

  // A match token: low byte first, escape byte when the code is 15, then drains.
  task automatic push_token(input int pos, input int code, input int extra, input int drains);
    push_req(OP_FEED, 8'({pos[3:0], code[3:0]}));
    push_req(OP_FEED, 8'(pos >> 4));
    if (code == 15) push_req(OP_FEED, 8'(extra));
    repeat (drains) push_req(OP_DRAIN, 8'($urandom));
  endtask

  // Well-formed flag groups with random content, sprinkled with noise and with
  // the occasional cut-short or disturbed match.
  task automatic push_stream(input int n);
    int          start;
    logic [7:0]  fb;
    int          code;
    int          extra;
    int          drains;
    start = request_q.size();
    while (request_q.size() - start < n) begin
      if ($urandom_range(0, 11) == 0) begin
        push_req(1'($urandom), 8'($urandom));
        continue;
      end
      fb = 8'($urandom);
      push_req(OP_FEED, fb);
      for (int i = 0; i < 8; i++) begin
        if (fb[i]) begin
          push_req(OP_FEED, 8'($urandom));
        end else begin
          code = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 15);
          extra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, 6);
          drains = code + (code == 15 ? extra : 0) + 2;
          push_token($urandom_range(0, 4095), code, extra, 0);
          for (int k = 0; k < drains; k++) begin
            if ($urandom_range(0, 30) == 0) push_req(OP_FEED, 8'($urandom));
            push_req(OP_DRAIN, 8'($urandom));
          end
          if ($urandom_range(0, 25) == 0) push_req(OP_DRAIN, 8'($urandom));
        end
      end
    end
  endtask

  // Waits until the driver has emptied its queue and every byte has come back,
  // then lets a worst-case match write-back finish.
  task automatic settle();
    while (request_q.size() != 0 || s_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    win_large = 1'b1;
    out_len = 32'd0;
    restart_stream();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (10) @(posedge clk);

    // Directed stream, large window. A match on the empty dictionary comes
    // first, then literal extremes, a drain with no match open and a byte fed
    // during a match. The escaped tokens with extra 0 and 255 are read as literals
    // under flag byte 1F, so their drains are ignored and the stream does not end.
    write_reg(REG_LARGE_WINDOW, 32'd1);
    write_reg(REG_OUTPUT_LENGTH, 32'd40);
    push_req(OP_FEED, 8'hFE);
    push_token(4095, 0, 0, 1);
    push_req(OP_FEED, 8'h55);
    push_req(OP_DRAIN, 8'h00);
    push_req(OP_FEED, 8'h00);
    push_req(OP_DRAIN, 8'hFF);
    push_req(OP_FEED, 8'hFF);
    push_req(OP_FEED, 8'h80);
    push_req(OP_FEED, 8'h01);
    push_req(OP_FEED, 8'h7F);
    push_req(OP_FEED, 8'hA5);
    push_req(OP_FEED, 8'h00);
    push_token(1, 15, 0, 17);
    push_token(2, 15, 255, 20);
    push_req(OP_FEED, 8'hFF);
    settle();

    // Zero output length: every request is ignored.
    write_reg(REG_OUTPUT_LENGTH, 32'd0);
    push_req(OP_FEED, 8'hFF);
    push_req(OP_FEED, 8'h12);
    push_req(OP_DRAIN, 8'h00);
    settle();

    // Small window, positions beyond it are folded back.
    write_reg(REG_LARGE_WINDOW, 32'd0);
    write_reg(REG_OUTPUT_LENGTH, 32'd60);
    push_req(OP_FEED, 8'h0F);
    push_req(OP_FEED, 8'h41);
    push_req(OP_FEED, 8'h42);
    push_req(OP_FEED, 8'h43);
    push_req(OP_FEED, 8'h44);
    push_token(4095, 2, 0, 4);
    push_token(2049, 0, 0, 2);
    settle();

    // Endless stream; the receiver holds off for a long time while requests
    // keep coming, and the window shrinks and grows in the middle.
    write_reg(REG_LARGE_WINDOW, 32'd1);
    write_reg(REG_OUTPUT_LENGTH, 32'hFFFF_FFFF);
    hold_request = 1;
    push_stream(220);
    settle();
    write_reg(REG_LARGE_WINDOW, 32'd0);
    push_stream(180);
    settle();
    write_reg(REG_LARGE_WINDOW, 32'd1);
    push_stream(110);
    settle();

    // Short streams of random length and window, often ending inside a match.
    for (int s = 0; s < 5; s++) begin
      write_reg(REG_LARGE_WINDOW, 32'($urandom_range(0, 1)));
      write_reg(REG_OUTPUT_LENGTH, 32'($urandom_range(1, 300)));
      push_stream(50);
      settle();
    end

    if (mismatches == 0) begin
      $display("lzss_decompressor_two_pass_dict verification clean");
    end else begin
      $display("lzss_decompressor_two_pass_dict verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("lzss_decompressor_two_pass_dict verification failed");
    $finish;
  end

endmodule
